FILE: sv/asc_pkg.sv
// Shared types and constants of the classifier head.
package asc_pkg;

    // Fixed field widths.
    localparam int LOGIT_W = 16;
    localparam int ID_W    = 16;
    localparam int LBL_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CONF_W  = 16;

    // Running maximum at the start of every group.
    localparam logic [LOGIT_W-1:0] MAX_RESET = 16'h8000;

    // Summary of one finished group, passed from front to back.
    typedef struct packed {
        logic [ID_W-1:0]    obj;
        logic [LBL_W-1:0]   label;
        logic [LOGIT_W-1:0] max_val;
        logic [CNT_W-1:0]   count;
        logic               ovf;
    } t_grp;

endpackage

FILE: sv/asc_front.sv
// Intake stage: stores logits, tracks the running maximum and issues finished groups.
module asc_front import asc_pkg::*; #(
    parameter int MAX_CLASSES = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_acc,
    input  logic [LOGIT_W-1:0]                   i_logit,
    input  logic                                 i_last,
    input  logic [ID_W-1:0]                      i_object_id,
    input  logic                                 i_keep,
    output logic                                 o_push,
    output t_grp                                 o_grp,
    output logic [MAX_CLASSES-1:0][LOGIT_W-1:0]  o_logits
);

    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [MAX_CLASSES-1:0][LOGIT_W-1:0] r_store, n_store;
    logic [CW-1:0]      r_count, n_count;
    logic [LOGIT_W-1:0] r_max, n_max;
    logic [LBL_W-1:0]   r_idx, n_idx;
    logic               r_ovf, n_ovf;
    logic               stored;

    // Classify the request: stored and compared, or dropped and flagged.
    always_comb begin
        n_store = r_store;
        n_count = r_count;
        n_max   = r_max;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        stored  = (r_count < CW'(MAX_CLASSES));
        if (i_acc) begin
            if (stored) begin
                n_store[r_count[IW-1:0]] = i_logit;
                if ($signed(i_logit) > $signed(r_max)) begin
                    n_max = i_logit;
                    n_idx = LBL_W'(r_count);
                end
                n_count = r_count + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // A kept group goes to the queue with the state that includes its last request.
    always_comb begin
        o_push        = i_acc & i_last & i_keep;
        o_grp.obj     = i_object_id;
        o_grp.label   = n_idx;
        o_grp.max_val = n_max;
        o_grp.count   = CNT_W'(n_count);
        o_grp.ovf     = n_ovf;
        o_logits      = n_store;
    end

    // Group state; the end of any group returns it to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= MAX_RESET;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_acc && i_last) begin
            r_count <= '0;
            r_max   <= MAX_RESET;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_max   <= n_max;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
        end
    end

    // Logit store needs no reset.
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

endmodule

FILE: sv/asc_queue.sv
// Two-entry queue that carries finished groups from front to back.
module asc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: sv/asc_back.sv
// Execution stage: sums exp terms over a group and divides for the confidence.
module asc_back import asc_pkg::*; #(
    parameter int MAX_CLASSES    = 8,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  t_grp                                 i_grp,
    input  logic [MAX_CLASSES-1:0][LOGIT_W-1:0]  i_logits,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [ID_W-1:0]                      o_out_object_id,
    output logic [LBL_W-1:0]                     o_label,
    output logic [CONF_W-1:0]                    o_confidence,
    output logic                                 o_overflowed
);

    localparam int TB     = EXP_TABLE_BITS;
    localparam int TSIZE  = 1 << TB;
    localparam int SH     = 12 - TB;
    localparam int IW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SUM_W  = 16 + $clog2(MAX_CLASSES + 1);
    localparam int QW     = 17;
    localparam int STEP_W = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SUM  = 3'b010,
        S_DIV  = 3'b100
    } t_bstate;

    // exp(-D/256) in Q16: series for exp(-D/65536) in Q30, then squared eight times.
    function automatic logic [16:0] exp_entry(input logic [11:0] span);
        longint unsigned t;
        longint unsigned term;
        longint unsigned y;
        t    = 64'(span) << 14;
        term = 64'd1 << 30;
        y    = 64'd1 << 30;
        term = (term * t) >> 30;
        y    = y - term;
        term = ((term * t) >> 30) / 2;
        y    = y + term;
        term = ((term * t) >> 30) / 3;
        y    = y - term;
        term = ((term * t) >> 30) / 4;
        y    = y + term;
        term = ((term * t) >> 30) / 5;
        y    = y - term;
        term = ((term * t) >> 30) / 6;
        y    = y + term;
        for (int n = 0; n < 8; n++) begin
            y = (y * y + (64'd1 << 29)) >> 30;
        end
        return 17'((y + (64'd1 << 13)) >> 14);
    endfunction

    // Constant exp table, built at elaboration.
    logic [16:0] exp_rom [TSIZE];
    for (genvar g = 0; g < TSIZE; g++) begin : g_rom
        assign exp_rom[g] = exp_entry(12'(g << SH));
    end

    t_bstate r_state;
    logic [MAX_CLASSES-1:0][LOGIT_W-1:0] r_logits;
    t_grp             r_grp;
    logic [CNT_W-1:0] r_idx;
    logic             r_dv, r_dz, r_tv;
    logic [TB-1:0]    r_addr;
    logic [16:0]      r_term;
    logic [SUM_W-1:0] r_sum, r_rem;
    logic [QW-1:0]    r_nlo, r_q;
    logic [STEP_W-1:0] r_step;

    logic             issue, sum_done, ge;
    logic [16:0]      diff;
    logic [32:0]      dividend;
    logic [SUM_W:0]   trial;
    logic [QW-1:0]    q_fin;

    // Distance of the current logit below the maximum.
    always_comb begin
        issue    = (r_state == S_SUM) && (r_idx < r_grp.count);
        diff     = {r_grp.max_val[15], r_grp.max_val}
                 - {r_logits[r_idx[IW-1:0]][15], r_logits[r_idx[IW-1:0]]};
        sum_done = (r_state == S_SUM) && !issue && !r_dv && !r_tv;
        dividend = {1'b1, 32'd0} + 33'(r_sum >> 1);
        trial    = {r_rem, r_nlo[QW-1]};
        ge       = (trial >= {1'b0, r_sum});
        q_fin    = {r_q[QW-2:0], ge};
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // Sequencer with the sum pipeline and the restoring divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_tv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_dv    <= issue;
            r_tv    <= r_dv;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(QW - 1)) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_logits <= i_logits;
            r_grp    <= i_grp;
            r_idx    <= '0;
            r_sum    <= '0;
        end
        if (issue) begin
            r_idx  <= r_idx + 1'b1;
            r_dz   <= (diff[15:12] != 4'd0);
            r_addr <= diff[11 -: TB];
        end
        if (r_dv) begin
            r_term <= r_dz ? 17'd0 : exp_rom[r_addr];
        end
        if (r_tv) begin
            r_sum <= r_sum + SUM_W'(r_term);
        end
        if (sum_done) begin
            r_rem  <= SUM_W'(dividend[32:QW]);
            r_nlo  <= dividend[QW-1:0];
            r_q    <= '0;
            r_step <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem  <= ge ? SUM_W'(trial - {1'b0, r_sum}) : SUM_W'(trial);
            r_nlo  <= {r_nlo[QW-2:0], 1'b0};
            r_q    <= q_fin;
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(QW - 1)) begin
                o_out_object_id <= r_grp.obj;
                o_label         <= r_grp.label;
                o_confidence    <= q_fin[QW-1] ? {CONF_W{1'b1}} : q_fin[CONF_W-1:0];
                o_overflowed    <= r_grp.ovf;
            end
        end
    end

endmodule

FILE: sv/argmax_softmax_confidence.sv
// Throughput: one logit request per cycle while busy is low; the back end works through
// one group at a time in its exp-sum pipeline and 17-step divider, and a two-deep queue
// lets the intake run ahead; busy rises only when that queue is full.
// Reset: synchronous, active low; clears group state, queue and sequencer.
// Results are single-cycle strobes: the receiver cannot stall.
module argmax_softmax_confidence import asc_pkg::*; #(
    parameter int MAX_CLASSES    = 8,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [LOGIT_W-1:0] i_logit,
    input  logic               i_last,
    input  logic [ID_W-1:0]    i_object_id,
    input  logic               i_keep,
    output logic               o_valid,
    output logic [ID_W-1:0]    o_out_object_id,
    output logic [LBL_W-1:0]   o_label,
    output logic [CONF_W-1:0]  o_confidence,
    output logic               o_overflowed
);

    localparam int LW = MAX_CLASSES * LOGIT_W;
    localparam int QW = LW + $bits(t_grp);

    logic                                acc, push, pop, q_empty, q_full;
    t_grp                                f_grp, b_grp;
    logic [MAX_CLASSES-1:0][LOGIT_W-1:0] f_logits, b_logits;
    logic [QW-1:0]                       q_in, q_out;

    // A request is taken whenever the queue has room.
    assign busy = q_full;
    assign acc  = start & ~busy;

    asc_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_logit     (i_logit),
        .i_last      (i_last),
        .i_object_id (i_object_id),
        .i_keep      (i_keep),
        .o_push      (push),
        .o_grp       (f_grp),
        .o_logits    (f_logits)
    );

    // Pack and unpack queue entries.
    assign q_in     = {f_grp, f_logits};
    assign b_grp    = q_out[QW-1:LW];
    assign b_logits = q_out[LW-1:0];

    asc_queue #(
        .W(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    asc_back #(
        .MAX_CLASSES    (MAX_CLASSES),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_grp           (b_grp),
        .i_logits        (b_logits),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_out_object_id (o_out_object_id),
        .o_label         (o_label),
        .o_confidence    (o_confidence),
        .o_overflowed    (o_overflowed)
    );

endmodule

FILE: dv/classifier_head_checker.sv
// Checker for the classifier head: predicts each kept group's verdict and compares it.
module classifier_head_checker import asc_pkg::*; #(
    parameter int MAX_CLASSES    = 8,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [LOGIT_W-1:0] i_logit,
    input  logic               i_last,
    input  logic [ID_W-1:0]    i_object_id,
    input  logic               i_keep,
    input  logic               o_valid,
    input  logic [ID_W-1:0]    o_out_object_id,
    input  logic [LBL_W-1:0]   o_label,
    input  logic [CONF_W-1:0]  o_confidence,
    input  logic               o_overflowed,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int LUT_SIZE   = 1 << EXP_TABLE_BITS;
    localparam int ADDR_SHIFT = 12 - EXP_TABLE_BITS;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [ID_W-1:0]   obj;
        logic [LBL_W-1:0]  label;
        logic [CONF_W-1:0] conf;
        logic              ovf;
    } t_verdict;

    t_verdict                  pending_verdicts[$];
    int unsigned               exp_weight_lut[LUT_SIZE];
    logic signed [LOGIT_W-1:0] held_logits[MAX_CLASSES];
    int unsigned               held_count;
    logic signed [LOGIT_W-1:0] best_logit;
    logic [LBL_W-1:0]          best_index;
    logic                      ovf_flag;
    int                        mismatches;

    // Q16 weight of exp(-span/256): six series terms in Q30, then squared eight times.
    function automatic int unsigned exp_weight(input int unsigned span);
        longint unsigned t;
        longint unsigned term;
        longint unsigned y;
        t    = longint'(span) << 14;
        term = 64'd1 << 30;
        y    = 64'd1 << 30;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * t) >> 30) / n;
            if (n % 2 == 1) begin
                y = y - term;
            end else begin
                y = y + term;
            end
        end
        for (int n = 0; n < 8; n++) begin
            y = (y * y + (64'd1 << 29)) >> 30;
        end
        return int'((y + (64'd1 << 13)) >> 14);
    endfunction

    // Group state returns to its starting values after every last request.
    function automatic void clear_group();
        held_count = 0;
        best_logit = MAX_RESET;
        best_index = '0;
        ovf_flag   = 1'b0;
    endfunction

    initial begin
        for (int k = 0; k < LUT_SIZE; k++) begin
            exp_weight_lut[k] = exp_weight(k << ADDR_SHIFT);
        end
    end

    // Track one accepted request and, on a kept group end, queue the verdict.
    task automatic classify_logit(input logic signed [LOGIT_W-1:0] logit, input logic last,
                                  input logic [ID_W-1:0] obj, input logic keep);
        t_verdict        v;
        longint unsigned sum;
        longint unsigned conf;
        int              delta;
        if (held_count < MAX_CLASSES) begin
            held_logits[held_count] = logit;
            if (logit > best_logit) begin
                best_logit = logit;
                best_index = LBL_W'(held_count);
            end
            held_count++;
        end else begin
            // Too many logits: this one is dropped and the group is flagged.
            ovf_flag = 1'b1;
        end
        if (last) begin
            if (keep) begin
                sum = 0;
                for (int i = 0; i < held_count; i++) begin
                    delta = int'(best_logit) - int'(held_logits[i]);
                    if (delta < 4096) begin
                        sum += exp_weight_lut[delta >> ADDR_SHIFT];
                    end
                end
                if (sum == 0) begin
                    sum = 1;
                end
                conf = ((64'd1 << 32) + sum / 2) / sum;
                if (conf > 65535) begin
                    conf = 65535;
                end
                v.obj   = obj;
                v.label = best_index;
                v.conf  = conf[CONF_W-1:0];
                v.ovf   = ovf_flag;
                pending_verdicts.insert(pending_verdicts.size(), v);
            end
            clear_group();
        end
    endtask

    // Compare one strobed result with the oldest verdict waiting.
    task automatic check_verdict();
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("[%0t] result with no request waiting: id %h label %0d conf %0d ovf %0b",
                         $realtime, o_out_object_id, o_label, o_confidence, o_overflowed);
            end
        end else begin
            want = pending_verdicts.pop_front();
            if (o_out_object_id !== want.obj || o_label !== want.label ||
                o_confidence !== want.conf || o_overflowed !== want.ovf) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED) begin
                    $display("[%0t] expected id %h label %0d conf %0d ovf %0b", $realtime,
                             want.obj, want.label, want.conf, want.ovf);
                    $display("[%0t] actual   id %h label %0d conf %0d ovf %0b", $realtime,
                             o_out_object_id, o_label, o_confidence, o_overflowed);
                end
            end
        end
    endtask

    // Sample both channels at each rising edge; results are checked before new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_group();
            pending_verdicts.delete();
            mismatches = 0;
        end else begin
            if (o_valid) begin
                check_verdict();
            end
            if (start && !busy) begin
                classify_logit(i_logit, i_last, i_object_id, i_keep);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_verdicts.size();
    end

endmodule

FILE: dv/tb.sv
// Testbench top for the classifier head: drives logit requests and reports the verdict.
module tb;
    import asc_pkg::*;

    localparam int MAX_CLASSES    = 8;
    localparam int EXP_TABLE_BITS = 8;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int MAX_GROUP      = 16;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic [LOGIT_W-1:0] i_logit     = '0;
    logic               i_last      = 1'b0;
    logic [ID_W-1:0]    i_object_id = '0;
    logic               i_keep      = 1'b0;
    logic               busy;
    logic               o_valid;
    logic [ID_W-1:0]    o_out_object_id;
    logic [LBL_W-1:0]   o_label;
    logic [CONF_W-1:0]  o_confidence;
    logic               o_overflowed;
    int                 fail_count;
    int                 pending;

    logic [LOGIT_W-1:0] group_logits[MAX_GROUP];
    int                 items_sent = 0;
    bit                 gaps_on    = 1'b1;

    argmax_softmax_confidence #(
        .MAX_CLASSES    (MAX_CLASSES),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_logit         (i_logit),
        .i_last          (i_last),
        .i_object_id     (i_object_id),
        .i_keep          (i_keep),
        .o_valid         (o_valid),
        .o_out_object_id (o_out_object_id),
        .o_label         (o_label),
        .o_confidence    (o_confidence),
        .o_overflowed    (o_overflowed)
    );

    classifier_head_checker #(
        .MAX_CLASSES    (MAX_CLASSES),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_logit         (i_logit),
        .i_last          (i_last),
        .i_object_id     (i_object_id),
        .i_keep          (i_keep),
        .o_valid         (o_valid),
        .o_out_object_id (o_out_object_id),
        .o_label         (o_label),
        .o_confidence    (o_confidence),
        .o_overflowed    (o_overflowed),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one request, with an occasional idle gap first, and hold it until taken.
    task automatic send_logit(input logic [LOGIT_W-1:0] logit, input logic last,
                              input logic [ID_W-1:0] obj, input logic keep);
        while (gaps_on && $urandom_range(99) < 13) begin
            start   <= 1'b0;
            i_logit <= LOGIT_W'($urandom);
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_logit     <= logit;
        i_last      <= last;
        i_object_id <= obj;
        i_keep      <= keep;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Send the first n entries of group_logits; id and keep only count on the last one.
    task automatic send_group(input int n, input logic [ID_W-1:0] obj, input logic keep);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
                send_logit(group_logits[i], 1'b1, obj, keep);
            end else begin
                send_logit(group_logits[i], 1'b0, ID_W'($urandom), 1'($urandom));
            end
        end
    endtask

    function automatic logic [LOGIT_W-1:0] clamp_logit(input int v);
        if (v > 32767) begin
            return 16'h7FFF;
        end else if (v < -32768) begin
            return 16'h8000;
        end
        return LOGIT_W'(v);
    endfunction

    // Fill a random group in one of several shapes, most of them close enough to matter.
    task automatic fill_group(input int n);
        int style;
        int base;
        logic [LOGIT_W-1:0] pair[2];
        style = $urandom_range(9);
        base  = int'($urandom_range(65535)) - 32768;
        pair[0] = LOGIT_W'($urandom);
        pair[1] = LOGIT_W'($urandom);
        for (int i = 0; i < n; i++) begin
            case (style)
                0, 1, 2: begin
                    group_logits[i] = LOGIT_W'($urandom);
                end
                3, 4, 5, 6: begin
                    group_logits[i] = clamp_logit(base - int'($urandom_range(5000)));
                end
                7: begin
                    group_logits[i] = pair[$urandom_range(1)];
                end
                8: begin
                    case ($urandom_range(4))
                        0: group_logits[i] = 16'h8000;
                        1: group_logits[i] = 16'h7FFF;
                        2: group_logits[i] = 16'h0000;
                        3: group_logits[i] = 16'hFFFF;
                        default: group_logits[i] = 16'h0001;
                    endcase
                end
                default: begin
                    group_logits[i] = clamp_logit(base + int'($urandom_range(63)));
                end
            endcase
        end
    endtask

    initial begin
        int n;
        int group_no;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single most negative logit: label 0, full confidence.
        group_logits[0] = 16'h8000;
        send_group(1, 16'h0000, 1'b1);

        // All equal: the first index wins and the probability is split evenly.
        for (int i = 0; i < 6; i++) group_logits[i] = 16'h1234;
        send_group(6, 16'hFFFF, 1'b1);

        // Maximum far from the rest, at the last place.
        for (int i = 0; i < 3; i++) group_logits[i] = 16'h8000;
        group_logits[3] = 16'h7FFF;
        send_group(4, 16'hA5A5, 1'b1);

        // One logit too many; the dropped one would have been the largest.
        group_logits[0] = 16'h0100; group_logits[1] = 16'h0000; group_logits[2] = 16'hFF00;
        group_logits[3] = 16'h0200; group_logits[4] = 16'h0180; group_logits[5] = 16'h0000;
        group_logits[6] = 16'h0100; group_logits[7] = 16'h0050; group_logits[8] = 16'h7FFF;
        send_group(9, 16'h5A5A, 1'b1);

        // Padding group gives nothing back.
        group_logits[0] = 16'h7FFF;
        group_logits[1] = 16'h0000;
        send_group(2, 16'h1111, 1'b0);

        // Distances just inside and just past the end of the exp table.
        group_logits[0] = 16'h1000;
        group_logits[1] = 16'h0001;
        group_logits[2] = 16'h0000;
        send_group(3, 16'h8001, 1'b1);

        // Random groups, with a long run free of idle gaps in the middle.
        items_sent = 0;
        group_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            gaps_on = !(group_no >= 90 && group_no < 170);
            if ($urandom_range(99) < 10) begin
                n = $urandom_range(MAX_CLASSES + 4, MAX_CLASSES + 1);
            end else begin
                n = $urandom_range(MAX_CLASSES, 1);
            end
            fill_group(n);
            send_group(n, ID_W'($urandom), $urandom_range(99) < 85);
            group_no++;
        end
        start <= 1'b0;

        // Drain, then allow for anything still in the back end.
        for (int k = 0; k < 4000 && pending != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
